// ===== sv/bxavg_pkg.sv =====
// ----------------------------------------------------------------------------
// bxavg_pkg: shared types and constants of the box average downscaler
// Field widths, register indexes, reset values and the word formats that
// travel between the front end, the op queue and the back end.
// ----------------------------------------------------------------------------
package bxavg_pkg;

  // Channel and field widths
  localparam int CH_N       = 4;
  localparam int PIX_W      = 8;
  localparam int POS_W      = 12;
  localparam int CNT_W      = 13;
  localparam int BS_W       = 5;
  localparam int AREA_W     = 2 * BS_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Reset values and limits
  localparam logic [BS_W-1:0]   RESET_BLOCK  = 5'd4;
  localparam logic [AREA_W-1:0] RESET_AREA   = 10'd16;
  localparam logic [CNT_W-1:0]  RESET_WIDTH  = 13'd1024;
  localparam logic [CNT_W-1:0]  RESET_HEIGHT = 13'd1024;
  localparam logic [CNT_W-1:0]  HEIGHT_CAP   = 13'd4096;

  // Divider: quotient bits and bits resolved per cycle
  localparam int QUOT_W     = 8;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = QUOT_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // Effective configuration (already clamped)
  typedef struct packed {
    logic [BS_W-1:0]   bs;
    logic [AREA_W-1:0] area;
    logic [CNT_W-1:0]  width;
    logic [CNT_W-1:0]  height;
  } cfg_t;

  // One accumulate operation on the line store
  typedef struct packed {
    logic [CH_N-1:0][PIX_W-1:0] px;
    logic [CNT_W-1:0]           addr;
    logic                       first;
    logic                       last;
    logic [POS_W-1:0]           col;
    logic [POS_W-1:0]           row;
  } op_t;

  // One averaged output pixel
  typedef struct packed {
    logic [CH_N-1:0][PIX_W-1:0] avg;
    logic [POS_W-1:0]           col;
    logic [POS_W-1:0]           row;
  } res_t;

endpackage

// ===== sv/bxavg_front.sv =====
// ----------------------------------------------------------------------------
// bxavg_front: raster position tracking and pixel classification
// Follows the pixel position in the frame and in the current block, drops
// pixels outside whole blocks and issues accumulate ops for the rest.
// ----------------------------------------------------------------------------
module bxavg_front (
  input  logic                                           clk,
  input  logic                                           rst,
  input  bxavg_pkg::cfg_t                                cfg,
  input  logic                                           restart,
  input  logic                                           accept,
  input  logic [bxavg_pkg::CH_N-1:0][bxavg_pkg::PIX_W-1:0] px,
  output logic                                           q_push,
  output bxavg_pkg::op_t                                 op
);

  logic [bxavg_pkg::CNT_W-1:0] pixel_col;
  logic [bxavg_pkg::CNT_W-1:0] pixel_row;
  logic [bxavg_pkg::BS_W-1:0]  col_in_block;
  logic [bxavg_pkg::BS_W-1:0]  row_in_block;
  logic [bxavg_pkg::CNT_W-1:0] blk_col;
  logic [bxavg_pkg::CNT_W-1:0] blk_row;

  logic [bxavg_pkg::CNT_W-1:0] col_start;
  logic [bxavg_pkg::CNT_W-1:0] row_start;
  logic [bxavg_pkg::CNT_W:0]   col_reach;
  logic [bxavg_pkg::CNT_W:0]   row_reach;
  logic                        col_fit;
  logic                        row_fit;
  logic                        last_col;
  logic                        last_row;
  logic                        line_end;
  logic                        frame_end;

  // Classify the current pixel against whole blocks
  always_comb begin
    col_start = pixel_col - bxavg_pkg::CNT_W'(col_in_block);
    row_start = pixel_row - bxavg_pkg::CNT_W'(row_in_block);
    col_reach = {1'b0, col_start} + (bxavg_pkg::CNT_W + 1)'(cfg.bs);
    row_reach = {1'b0, row_start} + (bxavg_pkg::CNT_W + 1)'(cfg.bs);
    col_fit   = col_reach <= {1'b0, cfg.width};
    row_fit   = row_reach <= {1'b0, cfg.height};
    last_col  = col_in_block == (cfg.bs - bxavg_pkg::BS_W'(1));
    last_row  = row_in_block == (cfg.bs - bxavg_pkg::BS_W'(1));
    line_end  = pixel_col == (cfg.width - bxavg_pkg::CNT_W'(1));
    frame_end = pixel_row == (cfg.height - bxavg_pkg::CNT_W'(1));
  end

  // Build the op word
  always_comb begin
    op.px    = px;
    op.addr  = blk_col;
    op.first = (col_in_block == '0) && (row_in_block == '0);
    op.last  = last_col && last_row;
    op.col   = blk_col[bxavg_pkg::POS_W-1:0];
    op.row   = blk_row[bxavg_pkg::POS_W-1:0];
    q_push   = accept && col_fit && row_fit;
  end

  // Advance the position counters, wrap at line and frame end
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pixel_col    <= '0;
      pixel_row    <= '0;
      col_in_block <= '0;
      row_in_block <= '0;
      blk_col      <= '0;
      blk_row      <= '0;
    end else if (accept) begin
      if (line_end) begin
        pixel_col    <= '0;
        col_in_block <= '0;
        blk_col      <= '0;
        if (frame_end) begin
          pixel_row    <= '0;
          row_in_block <= '0;
          blk_row      <= '0;
        end else begin
          pixel_row <= pixel_row + bxavg_pkg::CNT_W'(1);
          if (last_row) begin
            row_in_block <= '0;
            blk_row      <= blk_row + bxavg_pkg::CNT_W'(1);
          end else begin
            row_in_block <= row_in_block + bxavg_pkg::BS_W'(1);
          end
        end
      end else begin
        pixel_col <= pixel_col + bxavg_pkg::CNT_W'(1);
        if (last_col) begin
          col_in_block <= '0;
          blk_col      <= blk_col + bxavg_pkg::CNT_W'(1);
        end else begin
          col_in_block <= col_in_block + bxavg_pkg::BS_W'(1);
        end
      end
    end
  end

endmodule

// ===== sv/bxavg_queue.sv =====
// ----------------------------------------------------------------------------
// bxavg_queue: short op queue between front end and back end
// Register-based FIFO of accumulate ops; lets either side stall on its own.
// ----------------------------------------------------------------------------
module bxavg_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bxavg_pkg::op_t din,
  input  logic           pop,
  output bxavg_pkg::op_t dout,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bxavg_pkg::op_t   store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full    = count == CNT_W'(DEPTH);
    empty   = count == '0;
    do_push = push && !full;
    do_pop  = pop && !empty;
    dout    = store[rd_ptr];
  end

  // Write the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= din;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/bxavg_div.sv =====
// ----------------------------------------------------------------------------
// bxavg_div: block average divider
// Divides the four channel sums by the block area with a restoring
// divider, two quotient bits per cycle, and holds the result until taken.
// ----------------------------------------------------------------------------
module bxavg_div #(
  parameter int SUM_W = 17
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            start,
  output logic                                            ready,
  input  logic [bxavg_pkg::CH_N-1:0][SUM_W-1:0]           sums,
  input  logic [bxavg_pkg::AREA_W-1:0]                    area,
  input  logic [bxavg_pkg::POS_W-1:0]                     col,
  input  logic [bxavg_pkg::POS_W-1:0]                     row,
  output logic                                            done,
  input  logic                                            take,
  output bxavg_pkg::res_t                                 res
);

  logic                                                  busy;
  logic [bxavg_pkg::DIV_CNT_W-1:0]                       cnt;
  logic [bxavg_pkg::CH_N-1:0][SUM_W-1:0]                 rem;
  logic [SUM_W-1:0]                                      dvs;
  logic [bxavg_pkg::CH_N-1:0][bxavg_pkg::QUOT_W-1:0]     quo;
  logic [bxavg_pkg::POS_W-1:0]                           col_q;
  logic [bxavg_pkg::POS_W-1:0]                           row_q;

  logic [bxavg_pkg::CH_N-1:0][SUM_W-1:0]                 rem_next;
  logic [bxavg_pkg::CH_N-1:0][bxavg_pkg::DIV_STEPS-1:0]  qbits;
  logic [SUM_W-1:0]                                      dvs_next;

  assign ready = !busy || take;

  // Resolve two quotient bits per channel
  always_comb begin
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] d;
    for (int c = 0; c < bxavg_pkg::CH_N; c++) begin
      r = rem[c];
      d = dvs;
      for (int s = 0; s < bxavg_pkg::DIV_STEPS; s++) begin
        qbits[c][bxavg_pkg::DIV_STEPS-1-s] = r >= d;
        if (r >= d) begin
          r = r - d;
        end
        d = d >> 1;
      end
      rem_next[c] = r;
    end
    dvs_next = dvs >> bxavg_pkg::DIV_STEPS;
  end

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy && !done) begin
      cnt <= cnt + bxavg_pkg::DIV_CNT_W'(1);
      if (cnt == bxavg_pkg::DIV_CNT_W'(bxavg_pkg::DIV_CYCLES - 1)) begin
        done <= 1'b1;
      end
    end else if (take) begin
      busy <= 1'b0;
      done <= 1'b0;
    end
  end

  // Load operands, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= sums;
      dvs   <= SUM_W'(area) << (bxavg_pkg::QUOT_W - 1);
      quo   <= '0;
      col_q <= col;
      row_q <= row;
    end else if (busy && !done) begin
      rem <= rem_next;
      dvs <= dvs_next;
      for (int c = 0; c < bxavg_pkg::CH_N; c++) begin
        quo[c] <= {quo[c][bxavg_pkg::QUOT_W-bxavg_pkg::DIV_STEPS-1:0], qbits[c]};
      end
    end
  end

  always_comb begin
    res.avg = quo;
    res.col = col_q;
    res.row = row_q;
  end

endmodule

// ===== sv/bxavg_back.sv =====
// ----------------------------------------------------------------------------
// bxavg_back: line store accumulation and result output
// Reads the column-block sums, adds the pixel (with forwarding of the last
// write), writes back, hands finished blocks to the divider and holds the
// result word for the output side.
// ----------------------------------------------------------------------------
module bxavg_back #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_BLOCK = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [bxavg_pkg::AREA_W-1:0]   area,
  input  logic                           q_empty,
  input  bxavg_pkg::op_t                 q_dout,
  output logic                           q_pop,
  output logic                           empty,
  input  logic                           pop,
  output bxavg_pkg::res_t                res
);

  localparam int AW       = $clog2(MAX_WIDTH);
  localparam int BLK_CAP  = (MAX_BLOCK < 31) ? MAX_BLOCK : 31;
  localparam int SUM_W    = bxavg_pkg::PIX_W + $clog2(BLK_CAP * BLK_CAP + 1);

  typedef logic [bxavg_pkg::CH_N-1:0][SUM_W-1:0] sums_t;

  // Line store of per column-block channel sums
  sums_t            sums_mem [MAX_WIDTH];
  sums_t            rd_data;

  logic             s1_valid;
  bxavg_pkg::op_t   s1_op;
  logic [AW-1:0]    s1_addr;
  logic             fw_valid;
  logic [AW-1:0]    fw_addr;
  sums_t            fw_data;
  sums_t            base;
  sums_t            sum;
  logic             s1_adv;
  logic             div_start;
  logic             div_ready;
  logic             div_done;
  logic             div_take;
  bxavg_pkg::res_t  div_res;
  logic             out_valid;

  // Accumulate with forwarding of the previous write
  always_comb begin
    s1_addr = s1_op.addr[AW-1:0];
    base    = (fw_valid && (fw_addr == s1_addr)) ? fw_data : rd_data;
    for (int c = 0; c < bxavg_pkg::CH_N; c++) begin
      sum[c] = s1_op.first ? SUM_W'(s1_op.px[c]) : base[c] + SUM_W'(s1_op.px[c]);
    end
    s1_adv    = s1_valid && (!s1_op.last || div_ready);
    div_start = s1_valid && s1_op.last && div_ready;
    q_pop     = !q_empty && (!s1_valid || s1_adv);
  end

  // Line store write and registered read
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      sums_mem[s1_addr] <= sum;
    end
    if (q_pop) begin
      rd_data <= sums_mem[q_dout.addr[AW-1:0]];
    end
  end

  // Stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fw_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        fw_valid <= 1'b1;
      end
    end
  end

  // Stage payload and forwarding word
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_op <= q_dout;
    end
    if (s1_adv) begin
      fw_addr <= s1_addr;
      fw_data <= sum;
    end
  end

  bxavg_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .ready (div_ready),
    .sums  (sum),
    .area  (area),
    .col   (s1_op.col),
    .row   (s1_op.row),
    .done  (div_done),
    .take  (div_take),
    .res   (div_res)
  );

  // Output word register
  assign div_take = div_done && (!out_valid || pop);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      res <= div_res;
    end
  end

endmodule

// ===== sv/box_average_downscaler_top.sv =====
// Path: a word that completes a block passes through the op queue, the accumulate stage,
//   the divider and the output word register on its way to the output.
// Throughput: one pixel per cycle while nothing stalls; the divider resolves each block
//   result in 4 iterations of 2 bits, so block sizes below 5 can stall intake on the
//   last row of each block.
// Reset: synchronous; clears position counters, the op queue, divider and output word and
//   loads default registers. The line store is not cleared; no clearing pass.
// ----------------------------------------------------------------------------
// box_average_downscaler_top: RGBA box-filter frame downscaler
// Accumulates block_size by block_size squares of a raster pixel stream in
// a line store and outputs one averaged pixel per whole block.
// ----------------------------------------------------------------------------
module box_average_downscaler_top #(
  parameter int MAX_WIDTH   = 4096,
  parameter int MAX_BLOCK   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [bxavg_pkg::PIX_W-1:0]         red_in,
  input  logic [bxavg_pkg::PIX_W-1:0]         green_in,
  input  logic [bxavg_pkg::PIX_W-1:0]         blue_in,
  input  logic [bxavg_pkg::PIX_W-1:0]         alpha_in,
  output logic                                empty,
  input  logic                                pop,
  output logic [bxavg_pkg::PIX_W-1:0]         red_out,
  output logic [bxavg_pkg::PIX_W-1:0]         green_out,
  output logic [bxavg_pkg::PIX_W-1:0]         blue_out,
  output logic [bxavg_pkg::PIX_W-1:0]         alpha_out,
  output logic [bxavg_pkg::POS_W-1:0]         out_col,
  output logic [bxavg_pkg::POS_W-1:0]         out_row,
  input  logic                                cfg_we,
  input  logic [bxavg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bxavg_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bxavg_pkg::cfg_t                                  cfg;
  logic [bxavg_pkg::BS_W-1:0]                       bs_new;
  logic [bxavg_pkg::CNT_W-1:0]                      width_new;
  logic [bxavg_pkg::CNT_W-1:0]                      height_new;
  logic                                             restart;
  logic                                             accept;
  logic [bxavg_pkg::CH_N-1:0][bxavg_pkg::PIX_W-1:0] px;
  logic                                             q_push;
  bxavg_pkg::op_t                                   q_din;
  bxavg_pkg::op_t                                   q_dout;
  logic                                             q_pop;
  logic                                             q_empty;
  bxavg_pkg::res_t                                  res;

  // Clamp incoming register values
  always_comb begin
    bs_new = cfg_data[bxavg_pkg::BS_W-1:0];
    if (bs_new == '0) begin
      bs_new = bxavg_pkg::BS_W'(1);
    end else if (32'(bs_new) > MAX_BLOCK) begin
      bs_new = bxavg_pkg::BS_W'(MAX_BLOCK);
    end
    width_new = cfg_data;
    if (width_new == '0) begin
      width_new = bxavg_pkg::CNT_W'(1);
    end else if (32'(width_new) > MAX_WIDTH) begin
      width_new = bxavg_pkg::CNT_W'(MAX_WIDTH);
    end
    height_new = cfg_data;
    if (height_new == '0) begin
      height_new = bxavg_pkg::CNT_W'(1);
    end else if (height_new > bxavg_pkg::HEIGHT_CAP) begin
      height_new = bxavg_pkg::HEIGHT_CAP;
    end
  end

  // Decode writes that restart the frame
  always_comb begin
    unique case (cfg_index)
      bxavg_pkg::REG_BLOCK_SIZE,
      bxavg_pkg::REG_IMAGE_WIDTH,
      bxavg_pkg::REG_IMAGE_HEIGHT: restart = cfg_we;
      default:                     restart = 1'b0;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bs     <= bxavg_pkg::RESET_BLOCK;
      cfg.area   <= bxavg_pkg::RESET_AREA;
      cfg.width  <= bxavg_pkg::RESET_WIDTH;
      cfg.height <= bxavg_pkg::RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bxavg_pkg::REG_BLOCK_SIZE: begin
          cfg.bs   <= bs_new;
          cfg.area <= bxavg_pkg::AREA_W'(bs_new) * bxavg_pkg::AREA_W'(bs_new);
        end
        bxavg_pkg::REG_IMAGE_WIDTH:  cfg.width  <= width_new;
        bxavg_pkg::REG_IMAGE_HEIGHT: cfg.height <= height_new;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;
  assign px     = {alpha_in, blue_in, green_in, red_in};

  bxavg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .accept  (accept),
    .px      (px),
    .q_push  (q_push),
    .op      (q_din)
  );

  bxavg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (full),
    .empty (q_empty)
  );

  bxavg_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .area    (cfg.area),
    .q_empty (q_empty),
    .q_dout  (q_dout),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  // Unpack the result word
  assign red_out   = res.avg[0];
  assign green_out = res.avg[1];
  assign blue_out  = res.avg[2];
  assign alpha_out = res.avg[3];
  assign out_col   = res.col;
  assign out_row   = res.row;

endmodule

// ===== sv/bxavg_checker.sv =====
// ----------------------------------------------------------------------------
// bxavg_checker: port-level checks of the box average downscaler
// Watches the queue-style ports of the top level over time.
// ----------------------------------------------------------------------------
module bxavg_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             push,
  input logic                             full,
  input logic                             empty,
  input logic                             pop,
  input logic [bxavg_pkg::PIX_W-1:0]      red_out,
  input logic [bxavg_pkg::PIX_W-1:0]      green_out,
  input logic [bxavg_pkg::PIX_W-1:0]      blue_out,
  input logic [bxavg_pkg::PIX_W-1:0]      alpha_out,
  input logic [bxavg_pkg::POS_W-1:0]      out_col,
  input logic [bxavg_pkg::POS_W-1:0]      out_row
);

  // Come out of reset with nothing queued on either side
  a_reset_state: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (empty && !full))
    else $error("not empty or full right after reset");

  // Hold a waiting result word until it is popped
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(red_out) && $stable(green_out) &&
                          $stable(blue_out) && $stable(alpha_out) &&
                          $stable(out_col) && $stable(out_row)))
    else $error("waiting result word changed or vanished");

  // Drain the output only through a pop
  a_empty_by_pop: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(empty)) |-> $past(pop))
    else $error("result word dropped without a pop");

  // Fill the input queue only through a push
  a_full_by_push: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(full)) |-> $past(push))
    else $error("input side went full without a push");

endmodule

bind box_average_downscaler_top bxavg_checker u_checker (.*);

// ===== dv/box_average_downscaler_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_downscaler_top_test: self-checking bench of the box downscaler
// Streams RGBA pixels through a series of frame and block settings. A
// behavioral predictor works out each block average and its position, and
// a monitor checks every popped word against the oldest expected one.
// Both sides idle in random bursts and the output side stalls long enough
// to back up the input.
// ----------------------------------------------------------------------------
module box_average_downscaler_top_test;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_BLOCK    = 16;
  localparam int SETTLE_CYC   = 20;
  localparam int LONG_STALL   = 300;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int RANDOM_ITEMS = 430;
  localparam int CALM_ITEMS   = 330;
  localparam int PHASE_CAP    = 120;
  localparam logic [bxavg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Fill patterns of a phase
  typedef enum int {FILL_RANDOM, FILL_WHITE, FILL_BLACK, FILL_CHECKER} fill_t;

  typedef struct packed {
    logic [bxavg_pkg::PIX_W-1:0] r;
    logic [bxavg_pkg::PIX_W-1:0] g;
    logic [bxavg_pkg::PIX_W-1:0] b;
    logic [bxavg_pkg::PIX_W-1:0] a;
  } rgba_t;

  typedef struct packed {
    logic [bxavg_pkg::PIX_W-1:0] r;
    logic [bxavg_pkg::PIX_W-1:0] g;
    logic [bxavg_pkg::PIX_W-1:0] b;
    logic [bxavg_pkg::PIX_W-1:0] a;
    logic [bxavg_pkg::POS_W-1:0] col;
    logic [bxavg_pkg::POS_W-1:0] row;
  } avg_pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [bxavg_pkg::PIX_W-1:0] red_in = '0;
  logic [bxavg_pkg::PIX_W-1:0] green_in = '0;
  logic [bxavg_pkg::PIX_W-1:0] blue_in = '0;
  logic [bxavg_pkg::PIX_W-1:0] alpha_in = '0;
  logic empty;
  logic pop = 1'b0;
  logic [bxavg_pkg::PIX_W-1:0] red_out, green_out, blue_out, alpha_out;
  logic [bxavg_pkg::POS_W-1:0] out_col, out_row;
  logic cfg_we = 1'b0;
  logic [bxavg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bxavg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Stimulus and expectation stores
  rgba_t      pixel_queue[$];
  avg_pixel_t avg_expected[$];

  // Predictor state
  logic [bxavg_pkg::BS_W-1:0]  blk_reg;
  logic [bxavg_pkg::CNT_W-1:0] width_reg;
  logic [bxavg_pkg::CNT_W-1:0] height_reg;
  int unsigned line_sums [0:MAX_WIDTH-1][0:bxavg_pkg::CH_N-1];
  int unsigned pix_col, pix_row, col_in_blk, row_in_blk;

  int mismatches = 0;
  int cycles = 0;
  int idle_odds = 0;
  bit calm = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int stall_left = 0;
  int push_gap = 0;
  int pop_gap = 0;

  box_average_downscaler_top dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .alpha_in(alpha_in),
    .empty(empty), .pop(pop),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .alpha_out(alpha_out), .out_col(out_col), .out_row(out_row),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror a register write; any known register restarts the frame
  task automatic apply_reg(input logic [bxavg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bxavg_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      bxavg_pkg::REG_BLOCK_SIZE:   blk_reg = d[bxavg_pkg::BS_W-1:0];
      bxavg_pkg::REG_IMAGE_WIDTH:  width_reg = d;
      bxavg_pkg::REG_IMAGE_HEIGHT: height_reg = d;
      default: return;
    endcase
    pix_col = 0;
    pix_row = 0;
    col_in_blk = 0;
    row_in_blk = 0;
  endtask

  // Accumulate one pixel and queue the block average when a block closes
  task automatic accumulate_pixel(input rgba_t p);
    int unsigned bs, w, h, cb, area;
    int unsigned ch [0:bxavg_pkg::CH_N-1];
    bit first;
    avg_pixel_t o;
    ch[0] = 32'(p.r);
    ch[1] = 32'(p.g);
    ch[2] = 32'(p.b);
    ch[3] = 32'(p.a);
    bs = (blk_reg == '0) ? 1 : ((32'(blk_reg) > MAX_BLOCK) ? MAX_BLOCK : 32'(blk_reg));
    w = (width_reg == '0) ? 1 :
        ((32'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : 32'(width_reg));
    h = (height_reg == '0) ? 1 :
        ((height_reg > bxavg_pkg::HEIGHT_CAP) ? 32'(bxavg_pkg::HEIGHT_CAP)
                                              : 32'(height_reg));
    if (pix_col < (w / bs) * bs && pix_row < (h / bs) * bs) begin
      cb = (pix_col / bs) % MAX_WIDTH;
      first = (col_in_blk == 0 && row_in_blk == 0);
      for (int c = 0; c < bxavg_pkg::CH_N; c++)
        line_sums[cb][c] = first ? ch[c] : line_sums[cb][c] + ch[c];
      if (col_in_blk == bs - 1 && row_in_blk == bs - 1) begin
        area = bs * bs;
        o.r = bxavg_pkg::PIX_W'(line_sums[cb][0] / area);
        o.g = bxavg_pkg::PIX_W'(line_sums[cb][1] / area);
        o.b = bxavg_pkg::PIX_W'(line_sums[cb][2] / area);
        o.a = bxavg_pkg::PIX_W'(line_sums[cb][3] / area);
        o.col = bxavg_pkg::POS_W'(cb);
        o.row = bxavg_pkg::POS_W'(pix_row / bs);
        avg_expected.insert(avg_expected.size(), o);
      end
    end
    // Advance the raster position
    pix_col++;
    col_in_blk++;
    if (col_in_blk >= bs) col_in_blk = 0;
    if (pix_col >= w) begin
      pix_col = 0;
      col_in_blk = 0;
      pix_row++;
      row_in_blk++;
      if (row_in_blk >= bs) row_in_blk = 0;
      if (pix_row >= h) begin
        pix_row = 0;
        row_in_blk = 0;
      end
    end
  endtask

  // Compare one popped word with the oldest expectation
  task automatic check_avg_pixel();
    avg_pixel_t e;
    if (avg_expected.size() == 0) begin
      $error("unexpected word: col %0d row %0d", out_col, out_row);
      mismatches++;
      return;
    end
    e = avg_expected.pop_front();
    if (red_out !== e.r) begin
      $error("red_out expected %0d got %0d", e.r, red_out);
      mismatches++;
    end
    if (green_out !== e.g) begin
      $error("green_out expected %0d got %0d", e.g, green_out);
      mismatches++;
    end
    if (blue_out !== e.b) begin
      $error("blue_out expected %0d got %0d", e.b, blue_out);
      mismatches++;
    end
    if (alpha_out !== e.a) begin
      $error("alpha_out expected %0d got %0d", e.a, alpha_out);
      mismatches++;
    end
    if (out_col !== e.col) begin
      $error("out_col expected %0d got %0d", e.col, out_col);
      mismatches++;
    end
    if (out_row !== e.row) begin
      $error("out_row expected %0d got %0d", e.row, out_row);
      mismatches++;
    end
  endtask

  // Driver: hold a word until accepted, then load the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      push_gap = 0;
    end else if (push && full) begin
      push <= 1'b1;
    end else begin
      if (push) accumulate_pixel('{red_in, green_in, blue_in, alpha_in});
      if (push_gap > 0) begin
        push_gap--;
        push <= 1'b0;
      end else if (pixel_queue.size() == 0) begin
        push <= 1'b0;
      end else if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        push_gap = $urandom_range(1, 7) - 1;
        push <= 1'b0;
      end else begin
        {red_in, green_in, blue_in, alpha_in} <= pixel_queue.pop_front();
        push <= 1'b1;
      end
    end
  end

  // Monitor: check accepted words, then decide whether to pop next cycle
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_avg_pixel();
      if (hold_served != hold_requests) begin
        hold_served++;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (calm) begin
        pop <= 1'b1;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        pop_gap = $urandom_range(1, 7) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("box_average_downscaler_top_test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [bxavg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bxavg_pkg::CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, d);
  endtask

  // Wait until every word is sent and every expected result has arrived
  task automatic settle();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || push || avg_expected.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  function automatic logic [bxavg_pkg::PIX_W-1:0] rand_channel();
    int m;
    m = $urandom_range(0, 9);
    if (m == 0) return '0;
    if (m == 1) return '1;
    return bxavg_pkg::PIX_W'($urandom);
  endfunction

  task automatic queue_pixels(input int n, input fill_t fill);
    rgba_t p;
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_WHITE:   p = '1;
        FILL_BLACK:   p = '0;
        FILL_CHECKER: p = (i % 2 == 0) ? {8'hFF, 8'h00, 8'hFF, 8'h00}
                                       : {8'h00, 8'hFF, 8'h00, 8'hFF};
        default:      p = {rand_channel(), rand_channel(), rand_channel(), rand_channel()};
      endcase
      pixel_queue.insert(pixel_queue.size(), p);
    end
  endtask

  // Program all three registers, stream a run of pixels, drain
  task automatic run_phase(input logic [bxavg_pkg::CFG_DATA_W-1:0] bs_data,
                           input logic [bxavg_pkg::CFG_DATA_W-1:0] w,
                           input logic [bxavg_pkg::CFG_DATA_W-1:0] h,
                           input int n, input fill_t fill);
    write_reg(bxavg_pkg::REG_BLOCK_SIZE, bs_data);
    write_reg(bxavg_pkg::REG_IMAGE_WIDTH, w);
    write_reg(bxavg_pkg::REG_IMAGE_HEIGHT, h);
    queue_pixels(n, fill);
    settle();
  endtask

  initial begin
    int random_items;
    int bs, eff, w, h, frame, n;
    blk_reg = bxavg_pkg::RESET_BLOCK;
    width_reg = bxavg_pkg::RESET_WIDTH;
    height_reg = bxavg_pkg::RESET_HEIGHT;
    pix_col = 0;
    pix_row = 0;
    col_in_blk = 0;
    row_in_blk = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // Directed: extremes of pixel values and of the register handling
    idle_odds = 5;
    run_phase(13'd1, 13'd2, 13'd2, 4, FILL_CHECKER);
    run_phase(13'd2, 13'd2, 13'd2, 4, FILL_WHITE);
    // zero block size and zero frame size act as one
    run_phase(13'd0, 13'd0, 13'd0, 3, FILL_RANDOM);
    // frame smaller than a block gives nothing
    run_phase(13'd4, 13'd3, 13'd3, 6, FILL_RANDOM);
    // write to an unknown index must not restart the frame
    run_phase(13'd2, 13'd4, 13'd2, 4, FILL_BLACK);
    write_reg(REG_UNUSED, 13'h1FFF);
    queue_pixels(4, FILL_WHITE);
    settle();

    // Block size extremes: an oversized value clamps to the largest block,
    // with a trailing column that is dropped
    run_phase({8'hA5, 5'd31}, 13'd17, 13'd16, 17 * 16, FILL_RANDOM);

    // Frame extremes: oversized width and height clamp to the maximum
    run_phase(13'd1, 13'h1FFF, 13'd1, 16, FILL_RANDOM);
    run_phase(13'd1, 13'd0, 13'h1FFF, 16, FILL_RANDOM);
    run_phase(13'd2, 13'd4096, 13'd4096, 64, FILL_RANDOM);

    // Back up the input: stall the output side while every pixel closes a block
    write_reg(bxavg_pkg::REG_BLOCK_SIZE, 13'd1);
    write_reg(bxavg_pkg::REG_IMAGE_WIDTH, 13'd16);
    write_reg(bxavg_pkg::REG_IMAGE_HEIGHT, 13'd8);
    @(negedge clk);
    hold_requests++;
    queue_pixels(128, FILL_RANDOM);
    settle();

    // Random frames, mostly whole blocks with small sizes
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      n = $urandom_range(0, 19);
      if (n == 0) bs = 0;
      else if (n == 1) bs = $urandom_range(17, 31);
      else if (n < 4) bs = $urandom_range(6, 16);
      else bs = $urandom_range(1, 5);
      eff = (bs == 0) ? 1 : ((bs > MAX_BLOCK) ? MAX_BLOCK : bs);
      w = eff * $urandom_range(1, 4);
      h = eff * $urandom_range(1, 3);
      if ($urandom_range(0, 2) == 0) w += $urandom_range(0, eff - 1);
      if ($urandom_range(0, 2) == 0) h += $urandom_range(0, eff - 1);
      if ($urandom_range(0, 15) == 0) w = $urandom_range(0, eff);
      frame = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      n = frame * $urandom_range(1, 2);
      if ($urandom_range(0, 1) == 0) n += $urandom_range(0, frame - 1);
      if (n > PHASE_CAP) n = PHASE_CAP;
      case ($urandom_range(0, 3))
        0: idle_odds = 0;
        1: idle_odds = 3;
        default: idle_odds = 8;
      endcase
      if (random_items > CALM_ITEMS) calm = 1'b1;
      write_reg(bxavg_pkg::REG_BLOCK_SIZE,
                {(bxavg_pkg::CFG_DATA_W - bxavg_pkg::BS_W)'($urandom),
                 bxavg_pkg::BS_W'(bs)});
      write_reg(bxavg_pkg::REG_IMAGE_WIDTH, bxavg_pkg::CFG_DATA_W'(w));
      write_reg(bxavg_pkg::REG_IMAGE_HEIGHT, bxavg_pkg::CFG_DATA_W'(h));
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, bxavg_pkg::CFG_DATA_W'($urandom));
      queue_pixels(n, FILL_RANDOM);
      settle();
      random_items += n;
    end

    if (mismatches == 0 && avg_expected.size() == 0)
      $display("box_average_downscaler_top_test passed");
    else
      $display("box_average_downscaler_top_test failed");
    $finish;
  end

endmodule
